>>> rtl/core/bpt_pkg.sv
// Shared types, widths and constants for the Bezier path tessellator.
// No dependencies; every other file in rtl/core uses this package by scoped names.
`default_nettype none

package bpt_pkg;

    localparam int COORD_WIDTH  = 24;
    localparam int MAX_SEGMENTS = 31;
    localparam int SEG_W        = 5;
    localparam int CTL_W        = COORD_WIDTH + 1;
    localparam int T_W          = 17;
    localparam int W_W          = 49;
    localparam int PH_W         = 26 + CTL_W;
    localparam int PL_W         = 25 + CTL_W;
    localparam int ACC_W        = PH_W + 3;
    localparam int OUT_DEPTH    = 16;
    localparam int OUT_AW       = 4;
    localparam int CNT_W        = 5;

    localparam logic [SEG_W-1:0] SEG_RESET = 5'd16;
    localparam logic [T_W-1:0]   T_ONE     = 17'h10000;

    // Configuration register indexes (address bit 2)
    localparam logic CFG_SEGMENTS = 1'b0;
    localparam logic CFG_CLOSED   = 1'b1;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [CTL_W-1:0]       t_ctl;

    typedef enum logic [2:0] {
        START_ZERO = 3'b001,
        START_ONE  = 3'b010,
        START_END  = 3'b100
    } t_start;

    // One edge to tessellate
    typedef struct packed {
        t_ctl [3:0]       cx;
        t_ctl [3:0]       cy;
        t_start           start;
        logic [SEG_W-1:0] segs;
        logic             last_job;
        logic             fin;
    } t_job;

    typedef struct packed {
        t_coord x;
        t_coord y;
        logic   run_last;
        logic   path_end;
    } t_point;

    typedef struct packed {
        logic [T_W-1:0]   a;
        logic [SEG_W-1:0] b;
    } t_step;

    // Quotient and remainder of 65536 / s
    function automatic t_step step_of(input logic [SEG_W-1:0] s);
        t_step r;
        unique case (s)
            5'd2:    r = '{17'd32768, 5'd0};
            5'd3:    r = '{17'd21845, 5'd1};
            5'd4:    r = '{17'd16384, 5'd0};
            5'd5:    r = '{17'd13107, 5'd1};
            5'd6:    r = '{17'd10922, 5'd4};
            5'd7:    r = '{17'd9362,  5'd2};
            5'd8:    r = '{17'd8192,  5'd0};
            5'd9:    r = '{17'd7281,  5'd7};
            5'd10:   r = '{17'd6553,  5'd6};
            5'd11:   r = '{17'd5957,  5'd9};
            5'd12:   r = '{17'd5461,  5'd4};
            5'd13:   r = '{17'd5041,  5'd3};
            5'd14:   r = '{17'd4681,  5'd2};
            5'd15:   r = '{17'd4369,  5'd1};
            5'd16:   r = '{17'd4096,  5'd0};
            5'd17:   r = '{17'd3855,  5'd1};
            5'd18:   r = '{17'd3640,  5'd16};
            5'd19:   r = '{17'd3449,  5'd5};
            5'd20:   r = '{17'd3276,  5'd16};
            5'd21:   r = '{17'd3120,  5'd16};
            5'd22:   r = '{17'd2978,  5'd20};
            5'd23:   r = '{17'd2849,  5'd9};
            5'd24:   r = '{17'd2730,  5'd16};
            5'd25:   r = '{17'd2621,  5'd11};
            5'd26:   r = '{17'd2520,  5'd16};
            5'd27:   r = '{17'd2427,  5'd7};
            5'd28:   r = '{17'd2340,  5'd16};
            5'd29:   r = '{17'd2259,  5'd25};
            5'd30:   r = '{17'd2184,  5'd16};
            5'd31:   r = '{17'd2114,  5'd2};
            default: r = '{17'd65536, 5'd0};
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/bpt_front.sv
// Front end: accepts anchors, keeps path state and turns each anchor into edge jobs.
// Depends on bpt_pkg.
`default_nettype none

module bpt_front (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_push,
    output logic                       o_full,
    input  wire  bpt_pkg::t_coord      i_anchor_x,
    input  wire  bpt_pkg::t_coord      i_anchor_y,
    input  wire  bpt_pkg::t_coord      i_handle_in_x,
    input  wire  bpt_pkg::t_coord      i_handle_in_y,
    input  wire  bpt_pkg::t_coord      i_handle_out_x,
    input  wire  bpt_pkg::t_coord      i_handle_out_y,
    input  wire                        i_final_anchor,
    input  wire  [bpt_pkg::SEG_W-1:0]  i_segs,
    input  wire                        i_closed,
    output logic                       o_job_push,
    output bpt_pkg::t_job              o_job,
    input  wire                        i_job_full
);

    bpt_pkg::t_coord r_prev_px, r_prev_py, r_prev_hx, r_prev_hy;
    bpt_pkg::t_coord r_first_px, r_first_py, r_first_hx, r_first_hy;
    logic [1:0]      r_count;
    logic            r_pend_v;
    bpt_pkg::t_job   r_pend;

    logic          accept;
    logic          has_a;
    logic          needs_b;
    bpt_pkg::t_job job_a;
    bpt_pkg::t_job job_b;
    bpt_pkg::t_ctl px, py;

    assign o_full = r_pend_v || i_job_full;
    assign accept = i_push && !o_full;
    assign px     = bpt_pkg::CTL_W'(i_anchor_x);
    assign py     = bpt_pkg::CTL_W'(i_anchor_y);

    // Build the edge ending at this anchor, or the lone point
    always_comb begin
        job_a.segs     = i_segs;
        job_a.fin      = i_final_anchor;
        if (r_count == 2'd0) begin
            job_a.cx       = {px, px, px, px};
            job_a.cy       = {py, py, py, py};
            job_a.start    = bpt_pkg::START_END;
            job_a.last_job = 1'b1;
        end else begin
            job_a.cx[0]    = bpt_pkg::CTL_W'(r_prev_px);
            job_a.cy[0]    = bpt_pkg::CTL_W'(r_prev_py);
            job_a.cx[1]    = bpt_pkg::CTL_W'(r_prev_px) + bpt_pkg::CTL_W'(r_prev_hx);
            job_a.cy[1]    = bpt_pkg::CTL_W'(r_prev_py) + bpt_pkg::CTL_W'(r_prev_hy);
            job_a.cx[2]    = px + bpt_pkg::CTL_W'(i_handle_in_x);
            job_a.cy[2]    = py + bpt_pkg::CTL_W'(i_handle_in_y);
            job_a.cx[3]    = px;
            job_a.cy[3]    = py;
            job_a.start    = (r_count == 2'd1) ? bpt_pkg::START_ZERO : bpt_pkg::START_ONE;
            job_a.last_job = !(i_final_anchor && i_closed);
        end
    end

    // Build the closing edge back to the first anchor
    always_comb begin
        job_b.cx[0]    = px;
        job_b.cy[0]    = py;
        job_b.cx[1]    = px + bpt_pkg::CTL_W'(i_handle_out_x);
        job_b.cy[1]    = py + bpt_pkg::CTL_W'(i_handle_out_y);
        job_b.cx[2]    = bpt_pkg::CTL_W'(r_first_px) + bpt_pkg::CTL_W'(r_first_hx);
        job_b.cy[2]    = bpt_pkg::CTL_W'(r_first_py) + bpt_pkg::CTL_W'(r_first_hy);
        job_b.cx[3]    = bpt_pkg::CTL_W'(r_first_px);
        job_b.cy[3]    = bpt_pkg::CTL_W'(r_first_py);
        job_b.start    = bpt_pkg::START_ONE;
        job_b.segs     = i_segs;
        job_b.last_job = 1'b1;
        job_b.fin      = 1'b1;
    end

    assign has_a      = accept && ((r_count != 2'd0) || i_final_anchor);
    assign needs_b    = accept && (r_count != 2'd0) && i_final_anchor && i_closed;
    assign o_job_push = has_a || (r_pend_v && !i_job_full);
    assign o_job      = r_pend_v ? r_pend : job_a;

    // Hold the closing edge until the queue takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
        end else if (needs_b) begin
            r_pend_v <= 1'b1;
        end else if (r_pend_v && !i_job_full) begin
            r_pend_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (needs_b) begin
            r_pend <= job_b;
        end
    end

    // Advance path state on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_px  <= '0;
            r_prev_py  <= '0;
            r_prev_hx  <= '0;
            r_prev_hy  <= '0;
            r_first_px <= '0;
            r_first_py <= '0;
            r_first_hx <= '0;
            r_first_hy <= '0;
            r_count    <= 2'd0;
        end else if (accept) begin
            r_prev_px <= i_anchor_x;
            r_prev_py <= i_anchor_y;
            r_prev_hx <= i_handle_out_x;
            r_prev_hy <= i_handle_out_y;
            if (r_count == 2'd0) begin
                r_first_px <= i_anchor_x;
                r_first_py <= i_anchor_y;
                r_first_hx <= i_handle_in_x;
                r_first_hy <= i_handle_in_y;
            end
            if (i_final_anchor) begin
                r_count <= 2'd0;
            end else if (r_count != 2'd2) begin
                r_count <= r_count + 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/bpt_job_fifo.sv
// Two-entry queue of edge jobs between the front end and the evaluator.
// Depends on bpt_pkg.
`default_nettype none

module bpt_job_fifo (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_push,
    input  wire  bpt_pkg::t_job i_job,
    output logic           o_full,
    input  wire            i_pop,
    output bpt_pkg::t_job  o_head,
    output logic           o_empty
);

    bpt_pkg::t_job r_mem [2];
    logic          r_wr;
    logic          r_rd;
    logic [1:0]    r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_head  = r_mem[r_rd];

    // Store pushed jobs
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/bpt_back.sv
// Back end: steps t over each edge job, evaluates the Bernstein sum in a pipeline
// and buffers finished points in an output queue. Depends on bpt_pkg.
`default_nettype none

module bpt_back (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire  bpt_pkg::t_job i_job,
    input  wire             i_job_empty,
    output logic            o_job_pop,
    input  wire             i_pop,
    output logic            o_empty,
    output bpt_pkg::t_point o_point
);

    typedef enum logic [1:0] {
        B_IDLE = 2'b01,
        B_RUN  = 2'b10
    } t_bstate;

    localparam logic signed [bpt_pkg::ACC_W-1:0] ROUND =
        {{(bpt_pkg::ACC_W-24){1'b0}}, 1'b1, 23'b0};
    localparam logic signed [bpt_pkg::ACC_W-1:0] SAT_HI =
        {{(bpt_pkg::ACC_W-bpt_pkg::COORD_WIDTH+1){1'b0}}, {(bpt_pkg::COORD_WIDTH-1){1'b1}}};
    localparam logic signed [bpt_pkg::ACC_W-1:0] SAT_LO = ~SAT_HI;

    // Parameter stepper
    t_bstate                    r_state, n_state;
    bpt_pkg::t_job              r_job;
    logic [bpt_pkg::SEG_W-1:0]  r_i, n_i;
    logic [bpt_pkg::T_W-1:0]    r_q, n_q;
    logic [bpt_pkg::SEG_W:0]    r_r, n_r;
    bpt_pkg::t_step             r_st;
    logic [bpt_pkg::CNT_W-1:0]  r_credit;

    bpt_pkg::t_step             st_new;
    logic [bpt_pkg::SEG_W-1:0]  half;
    logic [bpt_pkg::SEG_W:0]    first_rem;
    logic [bpt_pkg::SEG_W:0]    sum_rem;
    logic                       issue;
    logic                       last_pt;
    logic                       pop_fire;

    // Pipeline registers
    logic                                r_p1_v, r_p2_v, r_p3_v, r_p4_v, r_p5_v, r_p6_v;
    logic [1:0]                          r_p1_f, r_p2_f, r_p3_f, r_p4_f, r_p5_f, r_p6_f;
    bpt_pkg::t_ctl [3:0]                 r_p1_cx, r_p1_cy, r_p2_cx, r_p2_cy, r_p3_cx, r_p3_cy;
    logic [bpt_pkg::T_W-1:0]             r_p1_t, r_p1_u, r_p2_t, r_p2_u;
    logic [2*bpt_pkg::T_W-1:0]           r_p2_u2, r_p2_t2;
    logic [3:0][bpt_pkg::W_W-1:0]        r_p3_w;
    logic signed [bpt_pkg::PH_W-1:0]     r_p4_phx [4];
    logic signed [bpt_pkg::PH_W-1:0]     r_p4_phy [4];
    logic signed [bpt_pkg::PL_W-1:0]     r_p4_plx [4];
    logic signed [bpt_pkg::PL_W-1:0]     r_p4_ply [4];
    logic signed [bpt_pkg::ACC_W-1:0]    r_p5_shx, r_p5_shy, r_p5_slx, r_p5_sly;
    logic signed [bpt_pkg::ACC_W-1:0]    r_p6_qx, r_p6_qy;

    logic [3*bpt_pkg::T_W-1:0]           m0, m1, m2, m3;
    logic [3*bpt_pkg::T_W+1:0]           m1x3, m2x3;
    logic signed [bpt_pkg::ACC_W-1:0]    shx, shy, slx, sly;
    logic signed [bpt_pkg::ACC_W-1:0]    rx, ry;
    bpt_pkg::t_point                     res;

    // Output queue
    bpt_pkg::t_point             r_omem [bpt_pkg::OUT_DEPTH];
    logic [bpt_pkg::OUT_AW-1:0]  r_owr, r_ord;
    logic [bpt_pkg::CNT_W-1:0]   r_ocnt;

    assign st_new    = bpt_pkg::step_of(i_job.segs);
    assign half      = i_job.segs >> 1;
    assign first_rem = (bpt_pkg::SEG_W+1)'(st_new.b) + (bpt_pkg::SEG_W+1)'(half);
    assign o_job_pop = (r_state == B_IDLE) && !i_job_empty;
    assign issue     = (r_state == B_RUN) && (r_credit < bpt_pkg::CNT_W'(bpt_pkg::OUT_DEPTH));
    assign last_pt   = (r_i == r_job.segs);
    assign sum_rem   = r_r + (bpt_pkg::SEG_W+1)'(r_st.b);
    assign pop_fire  = i_pop && !o_empty;

    // Load a job or step t by 1/segs
    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_q     = r_q;
        n_r     = r_r;
        unique case (r_state)
            B_IDLE: begin
                if (!i_job_empty) begin
                    n_state = B_RUN;
                    unique case (i_job.start)
                        bpt_pkg::START_ZERO: begin
                            n_i = '0;
                            n_q = '0;
                            n_r = (bpt_pkg::SEG_W+1)'(half);
                        end
                        bpt_pkg::START_ONE: begin
                            n_i = bpt_pkg::SEG_W'(1);
                            if (first_rem >= (bpt_pkg::SEG_W+1)'(i_job.segs)) begin
                                n_q = st_new.a + bpt_pkg::T_W'(1);
                                n_r = first_rem - (bpt_pkg::SEG_W+1)'(i_job.segs);
                            end else begin
                                n_q = st_new.a;
                                n_r = first_rem;
                            end
                        end
                        default: begin
                            n_i = i_job.segs;
                            n_q = bpt_pkg::T_ONE;
                            n_r = (bpt_pkg::SEG_W+1)'(half);
                        end
                    endcase
                end
            end
            default: begin
                if (issue) begin
                    if (last_pt) begin
                        n_state = B_IDLE;
                    end
                    n_i = r_i + bpt_pkg::SEG_W'(1);
                    if (sum_rem >= (bpt_pkg::SEG_W+1)'(r_job.segs)) begin
                        n_q = r_q + r_st.a + bpt_pkg::T_W'(1);
                        n_r = sum_rem - (bpt_pkg::SEG_W+1)'(r_job.segs);
                    end else begin
                        n_q = r_q + r_st.a;
                        n_r = sum_rem;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_credit <= '0;
        end else begin
            r_state  <= n_state;
            r_credit <= r_credit + bpt_pkg::CNT_W'(issue) - bpt_pkg::CNT_W'(pop_fire);
        end
    end

    always_ff @(posedge i_clk) begin
        r_i <= n_i;
        r_q <= n_q;
        r_r <= n_r;
        if (o_job_pop) begin
            r_job <= i_job;
            r_st  <= st_new;
        end
    end

    // Pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
            r_p2_v <= 1'b0;
            r_p3_v <= 1'b0;
            r_p4_v <= 1'b0;
            r_p5_v <= 1'b0;
            r_p6_v <= 1'b0;
        end else begin
            r_p1_v <= issue;
            r_p2_v <= r_p1_v;
            r_p3_v <= r_p2_v;
            r_p4_v <= r_p3_v;
            r_p5_v <= r_p4_v;
            r_p6_v <= r_p5_v;
        end
    end

    // Weights: squares, then cubes and the factor of three
    assign m0   = r_p2_u2 * r_p2_u;
    assign m1   = r_p2_u2 * r_p2_t;
    assign m2   = r_p2_t2 * r_p2_u;
    assign m3   = r_p2_t2 * r_p2_t;
    assign m1x3 = (3*bpt_pkg::T_W+2)'(m1) + {m1, 1'b0};
    assign m2x3 = (3*bpt_pkg::T_W+2)'(m2) + {m2, 1'b0};

    // Sum the split partial products
    always_comb begin
        shx = '0;
        shy = '0;
        slx = '0;
        sly = '0;
        for (int k = 0; k < 4; k++) begin
            shx = shx + bpt_pkg::ACC_W'(r_p4_phx[k]);
            shy = shy + bpt_pkg::ACC_W'(r_p4_phy[k]);
            slx = slx + bpt_pkg::ACC_W'(r_p4_plx[k]);
            sly = sly + bpt_pkg::ACC_W'(r_p4_ply[k]);
        end
    end

    // Round half up and saturate
    always_comb begin
        rx = (r_p6_qx + ROUND) >>> 24;
        ry = (r_p6_qy + ROUND) >>> 24;
        if (rx > SAT_HI) begin
            res.x = bpt_pkg::COORD_WIDTH'(SAT_HI);
        end else if (rx < SAT_LO) begin
            res.x = bpt_pkg::COORD_WIDTH'(SAT_LO);
        end else begin
            res.x = bpt_pkg::COORD_WIDTH'(rx);
        end
        if (ry > SAT_HI) begin
            res.y = bpt_pkg::COORD_WIDTH'(SAT_HI);
        end else if (ry < SAT_LO) begin
            res.y = bpt_pkg::COORD_WIDTH'(SAT_LO);
        end else begin
            res.y = bpt_pkg::COORD_WIDTH'(ry);
        end
        res.run_last = r_p6_f[1];
        res.path_end = r_p6_f[0];
    end

    // Pipeline payload
    always_ff @(posedge i_clk) begin
        r_p1_t  <= r_q;
        r_p1_u  <= bpt_pkg::T_ONE - r_q;
        r_p1_cx <= r_job.cx;
        r_p1_cy <= r_job.cy;
        r_p1_f  <= {r_job.last_job && last_pt, r_job.last_job && r_job.fin && last_pt};

        r_p2_u2 <= r_p1_u * r_p1_u;
        r_p2_t2 <= r_p1_t * r_p1_t;
        r_p2_u  <= r_p1_u;
        r_p2_t  <= r_p1_t;
        r_p2_cx <= r_p1_cx;
        r_p2_cy <= r_p1_cy;
        r_p2_f  <= r_p1_f;

        r_p3_w[0] <= m0[bpt_pkg::W_W-1:0];
        r_p3_w[1] <= m1x3[bpt_pkg::W_W-1:0];
        r_p3_w[2] <= m2x3[bpt_pkg::W_W-1:0];
        r_p3_w[3] <= m3[bpt_pkg::W_W-1:0];
        r_p3_cx   <= r_p2_cx;
        r_p3_cy   <= r_p2_cy;
        r_p3_f    <= r_p2_f;

        for (int k = 0; k < 4; k++) begin
            r_p4_phx[k] <= $signed({1'b0, r_p3_w[k][48:24]}) * r_p3_cx[k];
            r_p4_phy[k] <= $signed({1'b0, r_p3_w[k][48:24]}) * r_p3_cy[k];
            r_p4_plx[k] <= $signed({1'b0, r_p3_w[k][23:0]}) * r_p3_cx[k];
            r_p4_ply[k] <= $signed({1'b0, r_p3_w[k][23:0]}) * r_p3_cy[k];
        end
        r_p4_f <= r_p3_f;

        r_p5_shx <= shx;
        r_p5_shy <= shy;
        r_p5_slx <= slx;
        r_p5_sly <= sly;
        r_p5_f   <= r_p4_f;

        r_p6_qx <= r_p5_shx + (r_p5_slx >>> 24);
        r_p6_qy <= r_p5_shy + (r_p5_sly >>> 24);
        r_p6_f  <= r_p5_f;
    end

    // Output queue: write finished points, drop popped ones
    always_ff @(posedge i_clk) begin
        if (r_p6_v) begin
            r_omem[r_owr] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owr  <= '0;
            r_ord  <= '0;
            r_ocnt <= '0;
        end else begin
            if (r_p6_v) begin
                r_owr <= r_owr + bpt_pkg::OUT_AW'(1);
            end
            if (pop_fire) begin
                r_ord <= r_ord + bpt_pkg::OUT_AW'(1);
            end
            r_ocnt <= r_ocnt + bpt_pkg::CNT_W'(r_p6_v) - bpt_pkg::CNT_W'(pop_fire);
        end
    end

    assign o_empty = (r_ocnt == '0);
    assign o_point = r_omem[r_ord];

endmodule

`default_nettype wire

>>> rtl/core/bezier_path_tessellator.sv
// Top level of the cubic Bezier path tessellator: configuration registers,
// front end, job queue and evaluator. Depends on bpt_pkg, bpt_front, bpt_job_fifo, bpt_back.
//
// Usage:
//   Anchors enter through a queue-style port (push/full), one item per anchor,
//   final_anchor marking the end of a path. Points leave through a queue-style
//   port (empty/pop); run_last flags the last point of an anchor, path_end the
//   last point of the path.
//   The APB port writes segments_per_curve (address 0) and closed_path (address 4);
//   the user must write them only while the block is idle; the block does not enforce it.
//   Timing: an edge of S segments yields S or S+1 points at one point per cycle while
//   the point queue has credit, with a load step before each edge; a closing anchor
//   yields up to 2*S+1 points. The sequencer that steps t over each edge sets this rate.
//   An edge's first point goes from the job queue through the stepper and the pipeline.
//   A two-entry job queue lets the front end take the next anchor while an edge
//   is still being evaluated; a 16-entry point queue absorbs receiver stalls,
//   and the stepper pauses while the point queue has no free credit.
//   Reset: registers return to 16 segments, open path; path state and queues clear.
`default_nettype none

module bezier_path_tessellator (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         push,
    output logic                        full,
    input  wire  bpt_pkg::t_coord       i_anchor_x,
    input  wire  bpt_pkg::t_coord       i_anchor_y,
    input  wire  bpt_pkg::t_coord       i_handle_in_x,
    input  wire  bpt_pkg::t_coord       i_handle_in_y,
    input  wire  bpt_pkg::t_coord       i_handle_out_x,
    input  wire  bpt_pkg::t_coord       i_handle_out_y,
    input  wire                         i_final_anchor,
    output logic                        empty,
    input  wire                         pop,
    output bpt_pkg::t_coord             o_point_x,
    output bpt_pkg::t_coord             o_point_y,
    output logic                        o_run_last,
    output logic                        o_path_end,
    input  wire                         psel,
    input  wire                         penable,
    input  wire                         pwrite,
    input  wire  [2:0]                  paddr,
    input  wire  [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    logic [bpt_pkg::SEG_W-1:0] r_segs;
    logic                      r_closed;
    logic [bpt_pkg::SEG_W-1:0] segs_eff;
    logic                      cfg_wr;

    logic            job_push, job_full, job_pop, job_empty;
    bpt_pkg::t_job   job_in, job_head;
    bpt_pkg::t_point point;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_segs   <= bpt_pkg::SEG_RESET;
            r_closed <= 1'b0;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                bpt_pkg::CFG_SEGMENTS: r_segs   <= pwdata[bpt_pkg::SEG_W-1:0];
                bpt_pkg::CFG_CLOSED:   r_closed <= pwdata[0];
            endcase
        end
    end

    // Configuration reads
    always_comb begin
        unique case (paddr[2])
            bpt_pkg::CFG_SEGMENTS: prdata = 32'(r_segs);
            bpt_pkg::CFG_CLOSED:   prdata = 32'(r_closed);
        endcase
    end

    // Clamp the step count to 1..MAX_SEGMENTS
    always_comb begin
        if (r_segs == '0) begin
            segs_eff = bpt_pkg::SEG_W'(1);
        end else if (r_segs > bpt_pkg::SEG_W'(bpt_pkg::MAX_SEGMENTS)) begin
            segs_eff = bpt_pkg::SEG_W'(bpt_pkg::MAX_SEGMENTS);
        end else begin
            segs_eff = r_segs;
        end
    end

    bpt_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .o_full         (full),
        .i_anchor_x     (i_anchor_x),
        .i_anchor_y     (i_anchor_y),
        .i_handle_in_x  (i_handle_in_x),
        .i_handle_in_y  (i_handle_in_y),
        .i_handle_out_x (i_handle_out_x),
        .i_handle_out_y (i_handle_out_y),
        .i_final_anchor (i_final_anchor),
        .i_segs         (segs_eff),
        .i_closed       (r_closed),
        .o_job_push     (job_push),
        .o_job          (job_in),
        .i_job_full     (job_full)
    );

    bpt_job_fifo u_job_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job_in),
        .o_full  (job_full),
        .i_pop   (job_pop),
        .o_head  (job_head),
        .o_empty (job_empty)
    );

    bpt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (job_head),
        .i_job_empty (job_empty),
        .o_job_pop   (job_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_point     (point)
    );

    assign o_point_x  = point.x;
    assign o_point_y  = point.y;
    assign o_run_last = point.run_last;
    assign o_path_end = point.path_end;

    // Point queue comes out of reset empty
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("point queue not empty after reset");

    // The end of a path is always the end of an anchor's run
    a_end_is_run_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (!o_path_end || o_run_last))
        else $error("path_end without run_last");

    // A segments write lands in the register
    a_cfg_segs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cfg_wr && paddr[2] == bpt_pkg::CFG_SEGMENTS) |=> (r_segs == $past(pwdata[4:0])))
        else $error("segments write lost");

    // Job queue never pushed while full, unless a pop frees an entry at the same time
    a_job_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_full |-> !job_push || job_pop)
        else $error("job queue overflow");

endmodule

`default_nettype wire

>>> sim/bezier_path_tessellator_test.sv
// Testbench for bezier_path_tessellator: drives anchor paths, predicts every curve point
// with a local fixed-point model and checks each point as it leaves the block.
// Depends on bpt_pkg and the RTL under rtl/core.
`default_nettype none

module bezier_path_tessellator_test;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        bpt_pkg::t_coord ax, ay, hix, hiy, hox, hoy;
        logic            fin;
    } t_anchor;

    typedef struct {
        bpt_pkg::t_coord x, y;
        logic            run_last, path_end;
    } t_exp_point;

    localparam logic [2:0] ADDR_SEGMENTS = {bpt_pkg::CFG_SEGMENTS, 2'b00};
    localparam logic [2:0] ADDR_CLOSED   = {bpt_pkg::CFG_CLOSED, 2'b00};
    localparam int         COORD_MAX     = (1 << (bpt_pkg::COORD_WIDTH - 1)) - 1;
    localparam int         COORD_MIN     = -(1 << (bpt_pkg::COORD_WIDTH - 1));

    logic            i_clk;
    logic            i_rst_n;
    logic            push;
    logic            full;
    bpt_pkg::t_coord i_anchor_x, i_anchor_y, i_handle_in_x, i_handle_in_y;
    bpt_pkg::t_coord i_handle_out_x, i_handle_out_y;
    logic            i_final_anchor;
    logic            empty;
    logic            pop;
    bpt_pkg::t_coord o_point_x, o_point_y;
    logic            o_run_last, o_path_end;
    logic            psel, penable, pwrite;
    logic [2:0]      paddr;
    logic [31:0]     pwdata, prdata;
    logic            pready;

    bezier_path_tessellator u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_anchor_x     (i_anchor_x),
        .i_anchor_y     (i_anchor_y),
        .i_handle_in_x  (i_handle_in_x),
        .i_handle_in_y  (i_handle_in_y),
        .i_handle_out_x (i_handle_out_x),
        .i_handle_out_y (i_handle_out_y),
        .i_final_anchor (i_final_anchor),
        .empty          (empty),
        .pop            (pop),
        .o_point_x      (o_point_x),
        .o_point_y      (o_point_y),
        .o_run_last     (o_run_last),
        .o_path_end     (o_path_end),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // Predictor state and register shadow
    logic signed [63:0] last_px, last_py, last_hox, last_hoy;
    logic signed [63:0] head_px, head_py, head_hix, head_hiy;
    int unsigned        anchors_seen;
    logic [4:0]         seg_reg;
    logic               closed_reg;

    t_anchor     anchor_queue[$];
    t_exp_point  point_queue[$];
    int          error_count;
    int          points_seen;
    int          anchors_sent;
    int unsigned hold_cycles;
    int unsigned gap_left, burst_left;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic signed [63:0] sat_coord(input logic signed [63:0] v);
        if (v > COORD_MAX) return 64'(COORD_MAX);
        if (v < COORD_MIN) return 64'(COORD_MIN);
        return v;
    endfunction

    // Weighted Bernstein sum over 2^48, rounded half up, then saturated
    function automatic logic signed [63:0] blend(input logic [63:0] w[4],
                                                 input logic signed [63:0] c[4]);
        logic signed [127:0] acc;
        acc = 0;
        for (int k = 0; k < 4; k++)
            acc += $signed({64'd0, w[k]}) * $signed({{64{c[k][63]}}, c[k]});
        acc = (acc + (128'sd1 <<< 47)) >>> 48;
        return sat_coord(acc[63:0]);
    endfunction

    // Append the points of one edge, from step k0 to segs
    task automatic add_edge(input logic signed [63:0] cx[4], input logic signed [63:0] cy[4],
                            input int k0, input int segs);
        logic [63:0] t, u;
        logic [63:0] w[4];
        t_exp_point  p;
        for (int i = k0; i <= segs; i++) begin
            t = 64'((i * 65536 + segs / 2) / segs);
            u = 64'd65536 - t;
            w[0] = u * u * u;
            w[1] = 64'd3 * u * u * t;
            w[2] = 64'd3 * u * t * t;
            w[3] = t * t * t;
            p.x = bpt_pkg::t_coord'(blend(w, cx));
            p.y = bpt_pkg::t_coord'(blend(w, cy));
            p.run_last = 1'b0;
            p.path_end = 1'b0;
            point_queue.insert(point_queue.size(), p);
        end
    endtask

    task automatic predict_anchor(input t_anchor a);
        logic signed [63:0] cx[4], cy[4];
        int                 segs, prior_count;
        t_exp_point         p;
        segs = (seg_reg == 0) ? 1 : int'(seg_reg);
        prior_count = point_queue.size();
        if (anchors_seen == 0) begin
            head_px = 64'(a.ax); head_py = 64'(a.ay);
            head_hix = 64'(a.hix); head_hiy = 64'(a.hiy);
            if (a.fin) begin
                p.x = a.ax; p.y = a.ay; p.run_last = 1'b0; p.path_end = 1'b0;
                point_queue.insert(point_queue.size(), p);
            end
        end else begin
            cx[0] = last_px; cy[0] = last_py;
            cx[1] = last_px + last_hox; cy[1] = last_py + last_hoy;
            cx[2] = 64'(a.ax) + 64'(a.hix); cy[2] = 64'(a.ay) + 64'(a.hiy);
            cx[3] = 64'(a.ax); cy[3] = 64'(a.ay);
            add_edge(cx, cy, (anchors_seen == 1) ? 0 : 1, segs);
            if (a.fin && closed_reg) begin
                cx[0] = 64'(a.ax); cy[0] = 64'(a.ay);
                cx[1] = 64'(a.ax) + 64'(a.hox); cy[1] = 64'(a.ay) + 64'(a.hoy);
                cx[2] = head_px + head_hix; cy[2] = head_py + head_hiy;
                cx[3] = head_px; cy[3] = head_py;
                add_edge(cx, cy, 1, segs);
            end
        end
        last_px = 64'(a.ax); last_py = 64'(a.ay);
        last_hox = 64'(a.hox); last_hoy = 64'(a.hoy);
        if (a.fin) anchors_seen = 0;
        else if (anchors_seen < 2) anchors_seen++;
        if (point_queue.size() > prior_count) begin
            point_queue[$].run_last = 1'b1;
            point_queue[$].path_end = a.fin;
        end
    endtask

    // Driver: bursts with random gaps, fed from the pending anchor queue
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
            gap_left <= 0;
            burst_left <= 0;
        end else begin
            if (push && !full) begin
                predict_anchor(anchor_queue.pop_front());
                anchors_sent <= anchors_sent + 1;
            end
            if (push && full) begin
                // hold the offered item
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                push <= 1'b0;
            end else if ((anchor_queue.size() > 0) && !(push && anchor_queue.size() == 0)) begin
                push <= 1'b1;
                i_anchor_x <= anchor_queue[0].ax;
                i_anchor_y <= anchor_queue[0].ay;
                i_handle_in_x <= anchor_queue[0].hix;
                i_handle_in_y <= anchor_queue[0].hiy;
                i_handle_out_x <= anchor_queue[0].hox;
                i_handle_out_y <= anchor_queue[0].hoy;
                i_final_anchor <= anchor_queue[0].fin;
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(12, 1);
                    gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 0);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                push <= 1'b0;
            end
        end
    end

    // Monitor: pop on a stall pattern of its own, with a long hold-off when asked
    always @(posedge i_clk) begin
        t_exp_point exp_pt;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                points_seen <= points_seen + 1;
                if (point_queue.size() == 0) begin
                    $error("unexpected point x=%0d y=%0d", o_point_x, o_point_y);
                    error_count++;
                end else begin
                    exp_pt = point_queue.pop_front();
                    if (o_point_x !== exp_pt.x) begin
                        $error("point_x expected %0d got %0d", exp_pt.x, o_point_x);
                        error_count++;
                    end
                    if (o_point_y !== exp_pt.y) begin
                        $error("point_y expected %0d got %0d", exp_pt.y, o_point_y);
                        error_count++;
                    end
                    if (o_run_last !== exp_pt.run_last) begin
                        $error("run_last expected %0b got %0b", exp_pt.run_last, o_run_last);
                        error_count++;
                    end
                    if (o_path_end !== exp_pt.path_end) begin
                        $error("path_end expected %0b got %0b", exp_pt.path_end, o_path_end);
                        error_count++;
                    end
                end
            end
            if (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(7, 0) < 5);
            end
        end
    end

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (addr == ADDR_SEGMENTS) seg_reg = data[4:0];
        else closed_reg = data[0];
    endtask

    function automatic bpt_pkg::t_coord rand_coord(input int mode);
        case (mode)
            0: return bpt_pkg::t_coord'(COORD_MAX);
            1: return bpt_pkg::t_coord'(COORD_MIN);
            2: return bpt_pkg::t_coord'($urandom_range(4096, 0) - 2048);
            default: return bpt_pkg::t_coord'($urandom);
        endcase
    endfunction

    function automatic t_anchor make_anchor(input int mode, input logic fin);
        t_anchor a;
        a.ax = rand_coord(mode); a.ay = rand_coord(mode);
        a.hix = rand_coord(mode); a.hiy = rand_coord(mode);
        a.hox = rand_coord(mode); a.hoy = rand_coord(mode);
        a.fin = fin;
        return a;
    endfunction

    // Wait until every queued anchor is taken and every point has come back
    task automatic drain();
        while (anchor_queue.size() > 0 || push || point_queue.size() > 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic queue_path(input int len, input int mode);
        for (int k = 0; k < len; k++)
            anchor_queue.insert(anchor_queue.size(), make_anchor(mode, k == len - 1));
    endtask

    initial begin
        int            len;
        logic [4:0]    seg_pick;
        i_rst_n = 1'b0;
        push = 1'b0; pop = 1'b0;
        i_anchor_x = '0; i_anchor_y = '0; i_handle_in_x = '0; i_handle_in_y = '0;
        i_handle_out_x = '0; i_handle_out_y = '0; i_final_anchor = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        last_px = 0; last_py = 0; last_hox = 0; last_hoy = 0;
        head_px = 0; head_py = 0; head_hix = 0; head_hiy = 0;
        anchors_seen = 0; seg_reg = bpt_pkg::SEG_RESET; closed_reg = 1'b0;
        error_count = 0; points_seen = 0; anchors_sent = 0;
        hold_cycles = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset settings, lone anchor, open and closed paths at the extremes
        queue_path(1, 2);
        queue_path(3, 0);
        queue_path(3, 1);
        drain();
        reg_write(ADDR_CLOSED, 32'd1);
        reg_write(ADDR_SEGMENTS, 32'd31);
        queue_path(2, 3);
        queue_path(1, 3);
        queue_path(3, 0);
        drain();
        reg_write(ADDR_SEGMENTS, 32'd0);
        queue_path(3, 1);
        queue_path(2, 3);
        drain();
        reg_write(ADDR_SEGMENTS, 32'd1);
        reg_write(ADDR_CLOSED, 32'd0);
        queue_path(4, 3);
        drain();

        // Long receiver hold-off while anchors keep coming
        reg_write(ADDR_SEGMENTS, 32'd8);
        queue_path(6, 3);
        hold_cycles = 400;
        drain();

        // Random phases with fresh settings
        for (int ph = 0; ph < 8; ph++) begin
            seg_pick = (ph % 3 == 0) ? 5'($urandom_range(31, 0)) : 5'($urandom_range(6, 1));
            reg_write(ADDR_SEGMENTS, {27'd0, seg_pick});
            reg_write(ADDR_CLOSED, {31'd0, 1'($urandom)});
            for (int p = 0; p < 5; p++) begin
                len = $urandom_range(5, 1);
                queue_path(len, ($urandom_range(9, 0) == 0) ? $urandom_range(1, 0) : 3);
            end
            drain();
        end

        $display("Run covered %0d anchors and %0d points over several segment counts,",
                 anchors_sent, points_seen);
        $display("open and closed paths, lone anchors, saturation and a long output stall.");
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
